/* hdl/escape_sequence_key_matcher_assert.svh */
// assertion macros used by the matcher checker
`ifndef ESCAPE_SEQUENCE_KEY_MATCHER_ASSERT_SVH
`define ESCAPE_SEQUENCE_KEY_MATCHER_ASSERT_SVH

// checked only outside reset
`define ESCKM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// checked through reset as well
`define ESCKM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hdl/esckm_pkg.sv */
// constants, codes and types of the escape sequence key matcher
package esckm_pkg;

    localparam int ENTRIES  = 32;
    localparam int MAX_LEN  = 16;
    localparam int ENT_W    = $clog2(ENTRIES);
    localparam int NCNT_W   = $clog2(ENTRIES + 1);
    localparam int POS_W    = $clog2(MAX_LEN);
    localparam int CNT_W    = $clog2(MAX_LEN + 1);
    localparam int TB_DEPTH = ENTRIES * MAX_LEN;
    localparam int TB_AW    = $clog2(TB_DEPTH);

    // fixed field widths
    localparam int MODE_W   = 2;
    localparam int ENTRY_W  = 5;
    localparam int POSN_W   = 4;
    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int KEY_W    = 5;
    localparam int CFG_W    = 6;

    localparam logic [BYTE_W-1:0] ESC_BYTE = 8'd27;

    typedef logic [BYTE_W-1:0] t_byte;

    typedef enum logic [MODE_W-1:0] {
        MODE_TAB_BYTE = 2'd0,
        MODE_TAB_LEN  = 2'd1,
        MODE_BYTE     = 2'd2,
        MODE_SILENCE  = 2'd3
    } t_mode;

    typedef enum logic [KIND_W-1:0] {
        KIND_CHAR      = 2'd0,
        KIND_LONE_ESC  = 2'd1,
        KIND_KEY       = 2'd2,
        KIND_UNMATCHED = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_ESCAPED = 3'b010,
        PH_RUNNING = 3'b100
    } t_phase;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_EMIT = 4'b0100,
        ST_DUMP = 4'b1000
    } t_state;

    // verdict of the shared compare unit for one entry
    typedef struct packed {
        logic hit;
        logic final_byte;
    } t_cmp_res;

endpackage

/* hdl/esckm_in_if.sv */
// input item channel of the matcher
interface esckm_in_if;
    import esckm_pkg::*;

    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [ENTRY_W-1:0]  entry;
    logic [POSN_W-1:0]   position;
    logic [BYTE_W-1:0]   value;

    modport source (output valid, mode, entry, position, value, input ready);
    modport sink   (input valid, mode, entry, position, value, output ready);
endinterface

/* hdl/esckm_out_if.sv */
// result item channel of the matcher
interface esckm_out_if;
    import esckm_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [KEY_W-1:0]    key_index;
    logic [BYTE_W-1:0]   byte_value;
    logic                last;

    modport source (output valid, kind, key_index, byte_value, last, input ready);
    modport sink   (input valid, kind, key_index, byte_value, last, output ready);
endinterface

/* hdl/esckm_ram.sv */
// generic simple dual port ram with registered read
module esckm_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

/* hdl/esckm_cmp.sv */
// shared compare unit: checks one table entry against the latest captured byte
module esckm_cmp (
    input  logic                        i_cand,
    input  logic [esckm_pkg::CNT_W-1:0] i_len,
    input  logic [esckm_pkg::CNT_W-1:0] i_cnt,
    input  esckm_pkg::t_byte            i_tab_byte,
    input  esckm_pkg::t_byte            i_val,
    output esckm_pkg::t_cmp_res         o_res
);
    import esckm_pkg::*;

    logic [CNT_W:0] cnt_inc;

    // beyond the entry length or the buffer counts as a mismatch
    assign cnt_inc          = {1'b0, i_cnt} + {{CNT_W{1'b0}}, 1'b1};
    assign o_res.hit        = i_cand && (i_cnt < i_len) && (i_cnt < CNT_W'(MAX_LEN))
                              && (i_tab_byte == i_val);
    assign o_res.final_byte = o_res.hit && (cnt_inc == {1'b0, i_len});
endmodule

/* hdl/esckm_capture.sv */
// capture buffer holding the bytes of the current run
module esckm_capture (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [esckm_pkg::POS_W-1:0] i_wr_addr,
    input  esckm_pkg::t_byte            i_wr_data,
    input  logic [esckm_pkg::POS_W-1:0] i_rd_addr,
    output esckm_pkg::t_byte            o_rd_data
);
    import esckm_pkg::*;

    t_byte r_buf [MAX_LEN];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_buf[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_buf[i_rd_addr];
endmodule

/* hdl/escape_sequence_key_matcher.sv */
// escape sequence key matcher top level: sequencer, table rams and result register
// a byte in a run is checked against the n active entries (at most 32) in turn, stopping at the first match;
//   the table ram serves one entry per cycle to the compare unit
// silence after a run, or a full buffer, emits 1 captured byte per cycle, up to 16, as the output drains
// synchronous active-low reset clears sequencer, phase, capture count, flags and entry_count
module escape_sequence_key_matcher (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    esckm_in_if.sink                    i_item,
    esckm_out_if.source                 o_res,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [esckm_pkg::CFG_W-1:0] i_cfg_entry_count
);
    import esckm_pkg::*;

    t_state              r_state, n_state;
    t_phase              r_phase, n_phase;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [ENTRIES-1:0]  r_cand, n_cand;
    logic [CFG_W-1:0]    r_entry_count;
    t_byte               r_val, n_val;
    logic [NCNT_W-1:0]   r_issue, n_issue;
    logic                r_chk_vld, n_chk_vld;
    logic [ENT_W-1:0]    r_chk_idx, n_chk_idx;
    t_kind               r_pkind, n_pkind;
    logic [KEY_W-1:0]    r_pkey, n_pkey;
    t_byte               r_pbyte, n_pbyte;
    logic [POS_W-1:0]    r_dptr, n_dptr;
    logic                r_ov, n_ov;
    t_kind               r_okind, n_okind;
    logic [KEY_W-1:0]    r_okey, n_okey;
    t_byte               r_obyte, n_obyte;
    logic                r_olast, n_olast;

    logic [NCNT_W-1:0]   n_active;
    logic                in_acc;
    logic                slot_free;
    logic                issue_now;
    t_mode               in_mode;

    logic                tb_we;
    logic [TB_AW-1:0]    tb_wr_addr;
    logic [TB_AW-1:0]    tb_rd_addr;
    t_byte               tb_rd_data;
    logic                len_we;
    logic [ENT_W-1:0]    len_wr_addr;
    logic [CNT_W-1:0]    len_wr_data;
    logic [CNT_W-1:0]    len_rd_data;
    logic                cap_we;
    t_byte               cap_rd_data;
    t_cmp_res            cmp_res;
    logic                dump_last;

    assign o_cfg_ready  = 1'b1;
    assign i_item.ready = (r_state == ST_IDLE);
    assign in_acc       = i_item.valid && (r_state == ST_IDLE);
    assign in_mode      = t_mode'(i_item.mode);
    assign slot_free    = !r_ov || o_res.ready;

    assign n_active  = (r_entry_count > CFG_W'(ENTRIES)) ? NCNT_W'(ENTRIES)
                                                         : NCNT_W'(r_entry_count);
    assign issue_now = (r_issue < n_active);

    // table write and read addressing
    assign tb_wr_addr  = TB_AW'(i_item.entry) * TB_AW'(MAX_LEN) + TB_AW'(i_item.position);
    assign tb_rd_addr  = TB_AW'(r_issue[ENT_W-1:0]) * TB_AW'(MAX_LEN)
                         + TB_AW'(r_cnt[POS_W-1:0]);
    assign len_wr_addr = ENT_W'(i_item.entry);
    assign len_wr_data = (i_item.value > BYTE_W'(MAX_LEN)) ? CNT_W'(MAX_LEN)
                                                           : CNT_W'(i_item.value);
    assign dump_last   = ((CNT_W'(r_dptr) + CNT_W'(1)) == r_cnt);

    esckm_ram #(.WIDTH(BYTE_W), .DEPTH(TB_DEPTH)) u_tab_ram (
        .i_clk     (i_clk),
        .i_wr_en   (tb_we),
        .i_wr_addr (tb_wr_addr),
        .i_wr_data (i_item.value),
        .i_rd_addr (tb_rd_addr),
        .o_rd_data (tb_rd_data)
    );

    esckm_ram #(.WIDTH(CNT_W), .DEPTH(ENTRIES)) u_len_ram (
        .i_clk     (i_clk),
        .i_wr_en   (len_we),
        .i_wr_addr (len_wr_addr),
        .i_wr_data (len_wr_data),
        .i_rd_addr (r_issue[ENT_W-1:0]),
        .o_rd_data (len_rd_data)
    );

    esckm_capture u_capture (
        .i_clk     (i_clk),
        .i_wr_en   (cap_we),
        .i_wr_addr (r_cnt[POS_W-1:0]),
        .i_wr_data (i_item.value),
        .i_rd_addr (r_dptr),
        .o_rd_data (cap_rd_data)
    );

    esckm_cmp u_cmp (
        .i_cand     (r_cand[r_chk_idx]),
        .i_len      (len_rd_data),
        .i_cnt      (r_cnt),
        .i_tab_byte (tb_rd_data),
        .i_val      (r_val),
        .o_res      (cmp_res)
    );

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_cand    = r_cand;
        n_val     = r_val;
        n_issue   = r_issue;
        n_chk_vld = r_chk_vld;
        n_chk_idx = r_chk_idx;
        n_pkind   = r_pkind;
        n_pkey    = r_pkey;
        n_pbyte   = r_pbyte;
        n_dptr    = r_dptr;
        n_ov      = r_ov && !o_res.ready;
        n_okind   = r_okind;
        n_okey    = r_okey;
        n_obyte   = r_obyte;
        n_olast   = r_olast;
        tb_we     = 1'b0;
        len_we    = 1'b0;
        cap_we    = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (in_mode)
                        MODE_TAB_BYTE: begin
                            tb_we = (32'(i_item.entry) < ENTRIES)
                                    && (32'(i_item.position) < MAX_LEN);
                        end
                        MODE_TAB_LEN: begin
                            len_we = (32'(i_item.entry) < ENTRIES);
                        end
                        MODE_SILENCE: begin
                            if (r_phase == PH_ESCAPED) begin
                                n_pkind = KIND_LONE_ESC;
                                n_pkey  = '0;
                                n_pbyte = '0;
                                n_phase = PH_IDLE;
                                n_cnt   = '0;
                                n_state = ST_EMIT;
                            end else if (r_phase == PH_RUNNING) begin
                                n_dptr  = '0;
                                n_state = ST_DUMP;
                            end
                        end
                        MODE_BYTE: begin
                            if (r_phase == PH_IDLE) begin
                                if (i_item.value == ESC_BYTE) begin
                                    for (int i = 0; i < ENTRIES; i++) begin
                                        n_cand[i] = (NCNT_W'(i) < n_active);
                                    end
                                    n_cnt   = '0;
                                    n_phase = PH_ESCAPED;
                                end else if (i_item.value != '0) begin
                                    n_pkind = KIND_CHAR;
                                    n_pkey  = '0;
                                    n_pbyte = i_item.value;
                                    n_state = ST_EMIT;
                                end
                            end else if (r_cnt >= CNT_W'(MAX_LEN)) begin
                                n_dptr  = '0;
                                n_state = ST_DUMP;
                            end else begin
                                cap_we    = 1'b1;
                                n_cnt     = r_cnt + CNT_W'(1);
                                n_phase   = PH_RUNNING;
                                n_val     = i_item.value;
                                n_issue   = '0;
                                n_chk_vld = 1'b0;
                                n_state   = ST_SCAN;
                            end
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // read for entry r_issue goes out while the previous one is compared
                n_chk_vld = issue_now;
                n_chk_idx = r_issue[ENT_W-1:0];
                if (issue_now) begin
                    n_issue = r_issue + NCNT_W'(1);
                end
                if (r_chk_vld && cmp_res.final_byte) begin
                    n_pkind   = KIND_KEY;
                    n_pkey    = KEY_W'(r_chk_idx);
                    n_pbyte   = '0;
                    n_phase   = PH_IDLE;
                    n_cnt     = '0;
                    n_chk_vld = 1'b0;
                    n_state   = ST_EMIT;
                end else begin
                    if (r_chk_vld && !cmp_res.hit) begin
                        n_cand[r_chk_idx] = 1'b0;
                    end
                    if (!r_chk_vld && !issue_now) begin
                        if (r_cnt >= CNT_W'(MAX_LEN)) begin
                            n_dptr  = '0;
                            n_state = ST_DUMP;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_ov    = 1'b1;
                    n_okind = r_pkind;
                    n_okey  = r_pkey;
                    n_obyte = r_pbyte;
                    n_olast = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_DUMP: begin
                if (slot_free) begin
                    n_ov    = 1'b1;
                    n_okind = KIND_UNMATCHED;
                    n_okey  = '0;
                    n_obyte = cap_rd_data;
                    n_olast = dump_last;
                    n_dptr  = r_dptr + POS_W'(1);
                    if (dump_last) begin
                        n_phase = PH_IDLE;
                        n_cnt   = '0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_phase       <= PH_IDLE;
            r_cnt         <= '0;
            r_cand        <= '0;
            r_chk_vld     <= 1'b0;
            r_ov          <= 1'b0;
            r_entry_count <= '0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_cnt     <= n_cnt;
            r_cand    <= n_cand;
            r_chk_vld <= n_chk_vld;
            r_ov      <= n_ov;
            if (i_cfg_valid) begin
                r_entry_count <= i_cfg_entry_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val     <= n_val;
        r_issue   <= n_issue;
        r_chk_idx <= n_chk_idx;
        r_pkind   <= n_pkind;
        r_pkey    <= n_pkey;
        r_pbyte   <= n_pbyte;
        r_dptr    <= n_dptr;
        r_okind   <= n_okind;
        r_okey    <= n_okey;
        r_obyte   <= n_obyte;
        r_olast   <= n_olast;
    end

    assign o_res.valid      = r_ov;
    assign o_res.kind       = r_okind;
    assign o_res.key_index  = r_okey;
    assign o_res.byte_value = r_obyte;
    assign o_res.last       = r_olast;
endmodule

/* hdl/esckm_checker.sv */
// port checker for the matcher and its bind to the top level
`include "escape_sequence_key_matcher_assert.svh"

module esckm_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [esckm_pkg::KIND_W-1:0] i_out_kind,
    input  logic [esckm_pkg::KEY_W-1:0]  i_out_key_index,
    input  logic [esckm_pkg::BYTE_W-1:0] i_out_byte_value,
    input  logic                         i_out_last
);
    import esckm_pkg::*;

    `ESCKM_ASSERT_ALWAYS(a_rst_clears_out, !i_rst_n |=> !i_out_valid, "result valid after reset")
    `ESCKM_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_kind) && $stable(i_out_key_index) && $stable(i_out_byte_value) && $stable(i_out_last), "stalled result changed")
    `ESCKM_ASSERT(a_single_last, i_out_valid && (i_out_kind != KIND_UNMATCHED) |-> i_out_last, "single result without last")
    `ESCKM_ASSERT(a_key_only_on_match, i_out_valid && (i_out_kind != KIND_KEY) |-> (i_out_key_index == '0), "key index outside a match")
    `ESCKM_ASSERT(a_no_byte_on_event, i_out_valid && ((i_out_kind == KIND_KEY) || (i_out_kind == KIND_LONE_ESC)) |-> (i_out_byte_value == '0), "byte value on key event")
endmodule

bind escape_sequence_key_matcher esckm_checker u_esckm_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_res.valid),
    .i_out_ready      (o_res.ready),
    .i_out_kind       (o_res.kind),
    .i_out_key_index  (o_res.key_index),
    .i_out_byte_value (o_res.byte_value),
    .i_out_last       (o_res.last)
);
